// ===== sv/bitmap_span_allocator_assert.svh =====
// assertion macros for the span allocator
`ifndef BITMAP_SPAN_ALLOCATOR_ASSERT_SVH
`define BITMAP_SPAN_ALLOCATOR_ASSERT_SVH

`ifndef ASSERT_OFF
`define BSA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BSA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BSA_ASSERT(label, clk, rst_n, prop, msg)
`define BSA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== sv/bsa_pkg.sv =====
package bsa_pkg;

	localparam int NUM_UNITS_DEF = 1024;
	localparam int WORD_BITS = 32;
	localparam int WB_W = 5;
	localparam int SIZE_W = 13;
	localparam int ALIGN_W = 13;
	localparam int HANDLE_W = 10;
	localparam int INDEX_W = 10;
	localparam int POOL_W = 11;
	localparam int BASE_W = 10;
	localparam int CFG_DATA_W = 11;
	localparam int UNITS_W = 12;
	localparam int STEP_W = 11;
	localparam logic [POOL_W-1:0] POOL_RESET = 11'd1024;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_ZERO     = 3'd1,
		ST_NOSPACE  = 3'd2,
		ST_NULL     = 3'd3,
		ST_BADIDX   = 3'd4,
		ST_NOTALLOC = 3'd5
	} status_t;

	typedef enum logic {
		CFG_POOL_UNITS  = 1'b0,
		CFG_BASE_OFFSET = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		op_t                 operation;
		logic [SIZE_W-1:0]   size_bytes;
		logic [ALIGN_W-1:0]  align_bytes;
		logic [HANDLE_W-1:0] handle_unit;
		logic                handle_null;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [INDEX_W-1:0] unit_index;
	} rsp_t;

	typedef enum logic [3:0] {
		CMD_IDLE,
		CMD_CLEAR,
		CMD_LOAD,
		CMD_DIV,
		CMD_FETCH,
		CMD_SCAN,
		CMD_MREAD,
		CMD_MWRITE,
		CMD_RD_FIRST,
		CMD_RD_LAST,
		CMD_REPLY
	} dp_op_t;

	typedef struct packed {
		dp_op_t  op;
		status_t code;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_free;
		logic zero_size;
		logic null_req;
		logic bad_idx;
		logic div_last;
		logic scan_end;
		logic found;
		logic word_end;
		logic bit_used;
		logic last_oob;
		logic mark_last;
	} stat_t;

endpackage

// ===== sv/bsa_ram.sv =====
module bsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                    clk,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic                                    we,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end
endmodule

// ===== sv/bsa_ctrl.sv =====
module bsa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  bsa_pkg::stat_t stat,
	output bsa_pkg::cmd_t  cmd,
	output logic           busy
);
	import bsa_pkg::*;

	typedef enum logic [12:0] {
		S_CLEAR = 13'b0000000000001,
		S_IDLE  = 13'b0000000000010,
		S_DISP  = 13'b0000000000100,
		S_DIV   = 13'b0000000001000,
		S_FETCH = 13'b0000000010000,
		S_SCAN  = 13'b0000000100000,
		S_MRD   = 13'b0000001000000,
		S_MWR   = 13'b0000010000000,
		S_OK    = 13'b0000100000000,
		S_RDF   = 13'b0001000000000,
		S_TSTF  = 13'b0010000000000,
		S_TSTL  = 13'b0100000000000,
		S_RSV   = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '{op: CMD_IDLE, code: ST_OK};
		unique case (state_q)
			S_CLEAR: begin
				cmd.op = CMD_CLEAR;
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.op = CMD_LOAD;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				priority if (!stat.is_free && stat.zero_size) begin
					cmd = '{op: CMD_REPLY, code: ST_ZERO};
					state_d = S_IDLE;
				end else if (!stat.is_free) begin
					state_d = S_DIV;
				end else if (stat.null_req) begin
					cmd = '{op: CMD_REPLY, code: ST_NULL};
					state_d = S_IDLE;
				end else if (stat.bad_idx) begin
					cmd = '{op: CMD_REPLY, code: ST_BADIDX};
					state_d = S_IDLE;
				end else begin
					state_d = S_RDF;
				end
			end
			S_DIV: begin
				cmd.op = CMD_DIV;
				if (stat.div_last) state_d = S_FETCH;
			end
			S_FETCH: begin
				cmd.op = CMD_FETCH;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				priority if (stat.scan_end) begin
					cmd = '{op: CMD_REPLY, code: ST_NOSPACE};
					state_d = S_IDLE;
				end else begin
					cmd.op = CMD_SCAN;
					if (stat.found) state_d = S_MRD;
					else if (stat.word_end) state_d = S_FETCH;
				end
			end
			S_MRD: begin
				cmd.op = CMD_MREAD;
				state_d = S_MWR;
			end
			S_MWR: begin
				cmd.op = CMD_MWRITE;
				state_d = stat.mark_last ? S_OK : S_MRD;
			end
			S_OK: begin
				cmd = '{op: CMD_REPLY, code: ST_OK};
				state_d = S_IDLE;
			end
			S_RDF: begin
				cmd.op = CMD_RD_FIRST;
				state_d = S_TSTF;
			end
			S_TSTF: begin
				if (!stat.bit_used || stat.last_oob) begin
					cmd = '{op: CMD_REPLY, code: ST_NOTALLOC};
					state_d = S_IDLE;
				end else begin
					cmd.op = CMD_RD_LAST;
					state_d = S_TSTL;
				end
			end
			S_TSTL: begin
				priority if (!stat.bit_used) begin
					cmd = '{op: CMD_REPLY, code: ST_NOTALLOC};
					state_d = S_IDLE;
				end else if (stat.zero_size) begin
					cmd = '{op: CMD_REPLY, code: ST_OK};
					state_d = S_IDLE;
				end else begin
					state_d = S_MRD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
endmodule

// ===== sv/bsa_dp.sv =====
module bsa_dp #(
	parameter int NUM_UNITS = bsa_pkg::NUM_UNITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bsa_pkg::req_t                    req,
	input  bsa_pkg::cmd_t                    cmd,
	output bsa_pkg::stat_t                   stat,
	input  logic                             cfg_valid,
	input  bsa_pkg::cfg_idx_t                cfg_index,
	input  logic [bsa_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                             done,
	output bsa_pkg::rsp_t                    result
);
	import bsa_pkg::*;

	localparam int PW = ($clog2(NUM_UNITS) + 2 > 12) ? $clog2(NUM_UNITS) + 2 : 12;
	localparam int DW = PW + 1;
	localparam int CW = $clog2(DW);
	localparam int DEPTH = (NUM_UNITS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW = DEPTH > 1 ? $clog2(DEPTH) : 1;

	logic [POOL_W-1:0]   pool_q;
	logic [BASE_W-1:0]   base_q;
	op_t                 op_q;
	logic [UNITS_W-1:0]  units_q;
	logic [STEP_W-1:0]   step_q;
	logic [HANDLE_W-1:0] idx_q;
	logic                null_q;
	logic [PW-1:0]       hint_q, p_q, cand_q, first_q, s_q, ms_q, tpos_q;
	logic                cand_v_q, first_v_q;
	logic [DW-1:0]       dvd_q;
	logic [CW-1:0]       cnt_q;
	logic [STEP_W-1:0]   rem_q;
	logic [AW-1:0]       mw_q, clr_q;

	logic [PW-1:0]       lim, idx_w, units_w, last, mhi, c, runlen;
	logic [WORD_BITS-1:0] rdata, wdata;
	logic [AW-1:0]       addr;
	logic                we, re, free_b, aligned, have_c;
	logic [STEP_W:0]     rem_n, inc;
	logic [SIZE_W:0]     size_p3;
	logic [ALIGN_W-1:0]  align_eff;

	function automatic logic [AW-1:0] word_of(input logic [PW-1:0] x);
		return AW'(x >> WB_W);
	endfunction

	assign lim = ({{(PW-POOL_W){1'b0}}, pool_q} > PW'(NUM_UNITS)) ? PW'(NUM_UNITS)
		: {{(PW-POOL_W){1'b0}}, pool_q};
	assign idx_w = {{(PW-HANDLE_W){1'b0}}, idx_q};
	assign units_w = {{(PW-UNITS_W){1'b0}}, units_q};
	assign last = (units_q == '0) ? idx_w : idx_w + units_w - PW'(1);
	assign mhi = ms_q + units_w - PW'(1);

	// scan step over one unit
	assign free_b = !rdata[p_q[WB_W-1:0]];
	assign aligned = (rem_q == '0);
	assign c = cand_v_q ? cand_q : p_q;
	assign have_c = cand_v_q || aligned;
	assign runlen = p_q - c + PW'(1);
	assign inc = {1'b0, rem_q} + (STEP_W+1)'(1);

	assign rem_n = {rem_q, dvd_q[DW-1]};
	assign size_p3 = {1'b0, req.size_bytes} + (SIZE_W+1)'(3);
	assign align_eff = (req.align_bytes < ALIGN_W'(4)) ? ALIGN_W'(4) : req.align_bytes;

	always_comb begin
		stat.clr_last  = (clr_q == AW'(DEPTH - 1));
		stat.is_free   = (op_q == OP_FREE);
		stat.zero_size = (units_q == '0);
		stat.null_req  = null_q;
		stat.bad_idx   = (idx_w >= lim);
		stat.div_last  = (cnt_q == CW'(DW - 1));
		stat.scan_end  = (p_q >= lim);
		stat.found     = (p_q < lim) && free_b && have_c && (runlen >= units_w);
		stat.word_end  = &p_q[WB_W-1:0];
		stat.bit_used  = rdata[tpos_q[WB_W-1:0]];
		stat.last_oob  = (last >= lim);
		stat.mark_last = (mw_q == word_of(mhi));
	end

	always_comb begin
		addr = mw_q;
		we = 1'b0;
		re = 1'b0;
		unique case (cmd.op)
			CMD_CLEAR: begin
				addr = clr_q;
				we = 1'b1;
			end
			CMD_FETCH: begin
				addr = (p_q < lim) ? word_of(p_q) : '0;
				re = 1'b1;
			end
			CMD_MREAD: re = 1'b1;
			CMD_MWRITE: we = 1'b1;
			CMD_RD_FIRST: begin
				addr = word_of(idx_w);
				re = 1'b1;
			end
			CMD_RD_LAST: begin
				addr = word_of(last);
				re = 1'b1;
			end
			default: ;
		endcase
	end

	// set or clear the span bits within the current word, or clear the whole word in the reset sweep
	always_comb begin
		logic [PW-1:0] pos;
		wdata = rdata;
		for (int b = 0; b < WORD_BITS; b++) begin
			pos = (PW'(mw_q) << WB_W) | PW'(b);
			if (cmd.op == CMD_CLEAR) wdata[b] = 1'b0;
			else if (pos >= ms_q && pos <= mhi) wdata[b] = (op_q == OP_ALLOC);
		end
	end

	bsa_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_map (
		.clk   (clk),
		.addr  (addr),
		.we    (we),
		.wdata (wdata),
		.re    (re),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q <= POOL_RESET;
			base_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_POOL_UNITS:  pool_q <= cfg_data;
				CFG_BASE_OFFSET: base_q <= cfg_data[BASE_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hint_q <= '0;
			clr_q <= '0;
			done <= 1'b0;
			result <= '{status: ST_OK, unit_index: '0};
			op_q <= OP_ALLOC;
			units_q <= '0;
			null_q <= 1'b0;
			idx_q <= '0;
			cnt_q <= '0;
			cand_v_q <= 1'b0;
			first_v_q <= 1'b0;
			step_q <= '0;
			dvd_q <= '0;
			rem_q <= '0;
			p_q <= '0;
			cand_q <= '0;
			first_q <= '0;
			s_q <= '0;
			ms_q <= '0;
			mw_q <= '0;
			tpos_q <= '0;
		end else begin
			done <= (cmd.op == CMD_REPLY);
			unique case (cmd.op)
				CMD_CLEAR: clr_q <= clr_q + AW'(1);
				CMD_LOAD: begin
					op_q <= req.operation;
					units_q <= size_p3[SIZE_W:2];
					step_q <= align_eff[ALIGN_W-1:2];
					idx_q <= req.handle_unit;
					null_q <= req.handle_null;
					dvd_q <= DW'(base_q) + DW'(hint_q);
					rem_q <= '0;
					cnt_q <= '0;
					p_q <= hint_q;
					cand_v_q <= 1'b0;
					first_v_q <= 1'b0;
				end
				CMD_DIV: begin
					cnt_q <= cnt_q + CW'(1);
					dvd_q <= dvd_q << 1;
					rem_q <= (rem_n >= {1'b0, step_q}) ? STEP_W'(rem_n - {1'b0, step_q})
						: rem_n[STEP_W-1:0];
				end
				CMD_SCAN: begin
					p_q <= p_q + PW'(1);
					rem_q <= (inc == {1'b0, step_q}) ? '0 : inc[STEP_W-1:0];
					if (free_b) begin
						cand_v_q <= have_c;
						if (!cand_v_q && aligned) cand_q <= p_q;
						if (!first_v_q) begin
							first_v_q <= 1'b1;
							first_q <= p_q;
						end
					end else begin
						cand_v_q <= 1'b0;
					end
					// a fit at the first free unit moves the hint past the span
					if (stat.found && (first_v_q ? first_q : p_q) == c) hint_q <= c + units_w;
					else if (free_b && !first_v_q) hint_q <= p_q;
					if (stat.found) begin
						s_q <= c;
						ms_q <= c;
						mw_q <= word_of(c);
					end
				end
				CMD_MWRITE: mw_q <= mw_q + AW'(1);
				CMD_RD_FIRST: begin
					tpos_q <= idx_w;
					ms_q <= idx_w;
					mw_q <= word_of(idx_w);
				end
				CMD_RD_LAST: tpos_q <= last;
				CMD_REPLY: begin
					result.status <= cmd.code;
					result.unit_index <= (cmd.code == ST_OK && op_q == OP_ALLOC)
						? s_q[INDEX_W-1:0] : '0;
					if (cmd.code == ST_OK && op_q == OP_FREE && idx_w < hint_q) hint_q <= idx_w;
				end
				default: ;
			endcase
		end
	end
endmodule

// ===== sv/bitmap_span_allocator.sv =====
// First-fit span allocator over a bitmap of 4-byte units, held in a RAM of
// 32-unit words. A request is taken when start is high and busy is low; its
// one result shows on result for a single cycle with done high and cannot
// be stalled. Allocate: setup, a bit-serial divider for the alignment
// residue of the hint, a scan from the hint that fetches each map word it
// enters, then a read and a write per word of the span being marked. Free:
// the first and last units are checked, then each span word is read and rewritten.
// After reset the map is swept clear, a word at a time, with busy high.
// Configuration writes are always ready and are meant for idle periods.
module bitmap_span_allocator #(
	parameter int NUM_UNITS = bsa_pkg::NUM_UNITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  bsa_pkg::req_t                  req,
	output logic                           done,
	output bsa_pkg::rsp_t                  result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  bsa_pkg::cfg_idx_t              cfg_index,
	input  logic [bsa_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bsa_pkg::*;

	`include "bitmap_span_allocator_assert.svh"

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	bsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	bsa_dp #(.NUM_UNITS(NUM_UNITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.done      (done),
		.result    (result)
	);

	`BSA_ASSERT_NXT(a_busy_after_start, clk, arst_n, start && !busy, busy, "not busy after start")
	`BSA_ASSERT(a_index_only_ok, clk, arst_n, done && result.status != ST_OK |-> result.unit_index == '0, "index on failed result")
	`BSA_ASSERT(a_done_idle, clk, arst_n, done |-> !busy, "result while still busy")
endmodule
